// ----- sv/szpd_pkg.sv -----
package szpd_pkg;

  localparam int unsigned LEN_W     = 7;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned INFL_W    = 17;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned SUM_W     = 31;
  localparam int unsigned SQ_W      = 54;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned VAR_W     = 64;
  localparam int unsigned CMP_W     = 96;
  localparam int unsigned BL_W      = 43;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLUENCE     = 2'd2;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd16;
  localparam logic [LEN_W-1:0]  LEN_MIN    = 7'd2;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd768;
  localparam logic [INFL_W-1:0] INFL_RESET = 17'd0;
  localparam logic [INFL_W-1:0] INFL_ONE   = 17'h10000;

  localparam logic signed [1:0] SIG_NONE = 2'sb00;
  localparam logic signed [1:0] SIG_POS  = 2'sb01;
  localparam logic signed [1:0] SIG_NEG  = 2'sb11;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    restart;
  } smp_item_t;

  typedef struct packed {
    logic signed [1:0] peak_signal;
    logic              ready_res;
  } res_item_t;

endpackage

// ----- sv/szpd_mul.sv -----
module szpd_mul
  import szpd_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- sv/smoothed_zscore_peak_detector.sv -----
// Channel  Signals                              Direction  Moves
// smp      smp_valid smp_ready smp_data         in         one sample item
// res      res_valid res_ready res_data         out        one result item
// cfg      cfg_valid cfg_ready cfg_index cfg_data  in      one register write
//
// While the window fills, an accepted item runs ST_FF, ST_PUSH and ST_OUT; once
// it is full, ST_LX through ST_BL come first. The result is registered as ST_OUT is
// left. Test products share the one registered 32x32 multiplier; the ring memory
// is read on acceptance and written back at the end. One item is in work at a time.
// Reset is synchronous; it clears sums, counts and registers, not the ring.
// A finished result waits in the output register; the next item is taken meanwhile.
module smoothed_zscore_peak_detector
  import szpd_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 smp_valid,
  output logic                 smp_ready,
  input  smp_item_t            smp_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_item_t            res_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LMAX  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam int unsigned IW    = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam logic [LEN_W-1:0] LMAX_V = LEN_W'(LMAX);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_LX   = 15'b000000000000010,
    ST_SS   = 15'b000000000000100,
    ST_LQL  = 15'b000000000001000,
    ST_LQH  = 15'b000000000010000,
    ST_DD   = 15'b000000000100000,
    ST_TT   = 15'b000000001000000,
    ST_RL   = 15'b000000010000000,
    ST_RH   = 15'b000000100000000,
    ST_CMP  = 15'b000001000000000,
    ST_DEC  = 15'b000010000000000,
    ST_BL   = 15'b000100000000000,
    ST_FF   = 15'b001000000000000,
    ST_PUSH = 15'b010000000000000,
    ST_OUT  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic [LEN_W-1:0]  wl_q;
  logic [THR_W-1:0]  thr_q;
  logic [INFL_W-1:0] infl_q;

  logic signed [VAL_W-1:0] mem [WINDOW_MAX];
  logic signed [VAL_W-1:0] rd_q;

  logic signed [VAL_W-1:0] x_q;
  logic signed [VAL_W-1:0] f_q;
  logic signed [VAL_W-1:0] last_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sq_q;
  logic [LEN_W-1:0]        fill_q;
  logic [IDX_W-1:0]        wi_q;
  logic [SUM_W-1:0]        d_mag_q;
  logic                    d_pos_q;
  logic [VAR_W-1:0]        var_q;
  logic [CMP_W-1:0]        lhs_q;
  logic [CMP_W-1:0]        rhs_q;
  logic [MUL_W-1:0]        thr2_q;
  logic                    flag_q;
  logic                    bneg_q;
  logic                    rdy_q;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  logic [LEN_W-1:0]        l_cur;
  logic                    accept;
  logic                    clr;
  logic [LEN_W-1:0]        fill_eff;
  logic                    rdy_i;
  logic [IDX_W-1:0]        wi_eff;
  logic [IW:0]             wi_inc;
  logic [IDX_W-1:0]        wi_next;
  logic signed [VAL_W-1:0] x_in;
  logic [VAL_W-1:0]        x_mag;
  logic [VAL_W-1:0]        rd_mag;
  logic [VAL_W-1:0]        f_mag;
  logic [SUM_W-1:0]        s_mag;
  logic signed [MUL_W-1:0] lx;
  logic signed [MUL_W-1:0] d;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          diff_mag;
  logic [INFL_W-1:0]       w_sat;
  logic signed [BL_W-1:0]  bp;
  logic signed [BL_W-1:0]  rnd;
  logic signed [VAL_W-1:0] blend;

  szpd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign smp_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = smp_valid && smp_ready;

  assign l_cur    = (wl_q < LEN_MIN) ? LEN_MIN : ((wl_q > LMAX_V) ? LMAX_V : wl_q);
  assign clr      = smp_data.restart || (fill_q > l_cur);
  assign fill_eff = clr ? '0 : fill_q;
  assign rdy_i    = (fill_eff == l_cur);
  assign wi_eff   = (clr || (IW'(wi_q) >= IW'(l_cur))) ? '0 : wi_q;
  assign wi_inc   = (IW + 1)'(wi_q) + (IW + 1)'(1);
  assign wi_next  = (wi_inc >= (IW + 1)'(l_cur)) ? '0 : wi_inc[IDX_W-1:0];

  assign x_in   = {smp_data.sample, 8'b0};
  assign x_mag  = x_q[VAL_W-1] ? VAL_W'(-x_q) : VAL_W'(x_q);
  assign rd_mag = rd_q[VAL_W-1] ? VAL_W'(-rd_q) : VAL_W'(rd_q);
  assign f_mag  = f_q[VAL_W-1] ? VAL_W'(-f_q) : VAL_W'(f_q);
  assign s_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign lx = x_q[VAL_W-1] ? -$signed(prod[MUL_W-1:0]) : $signed(prod[MUL_W-1:0]);
  assign d  = lx - MUL_W'(sum_q);

  assign diff     = (VAL_W + 1)'(x_q) - (VAL_W + 1)'(last_q);
  assign diff_mag = diff[VAL_W] ? (VAL_W + 1)'(-diff) : (VAL_W + 1)'(diff);
  assign w_sat    = (infl_q > INFL_ONE) ? INFL_ONE : infl_q;

  assign bp    = bneg_q ? -$signed({2'b00, prod[BL_W-3:0]}) : $signed({2'b00, prod[BL_W-3:0]});
  assign rnd   = (bp + BL_W'(32768)) >>> 16;
  assign blend = last_q + $signed(rnd[VAL_W-1:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_LX: begin
        mul_a = MUL_W'(l_cur);
        mul_b = MUL_W'(x_mag);
      end
      ST_SS: begin
        mul_a = MUL_W'(s_mag);
        mul_b = MUL_W'(s_mag);
      end
      ST_LQL: begin
        mul_a = MUL_W'(l_cur);
        mul_b = sq_q[MUL_W-1:0];
      end
      ST_LQH: begin
        mul_a = MUL_W'(l_cur);
        mul_b = MUL_W'(sq_q[SQ_W-1:MUL_W]);
      end
      ST_DD: begin
        mul_a = MUL_W'(d_mag_q);
        mul_b = MUL_W'(d_mag_q);
      end
      ST_TT: begin
        mul_a = MUL_W'(thr_q);
        mul_b = MUL_W'(thr_q);
      end
      ST_RL: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = var_q[MUL_W-1:0];
      end
      ST_RH: begin
        mul_a = thr2_q;
        mul_b = var_q[VAR_W-1:MUL_W];
      end
      ST_CMP: begin
        mul_a = MUL_W'(rd_mag);
        mul_b = MUL_W'(rd_mag);
      end
      ST_DEC: begin
        mul_a = MUL_W'(w_sat);
        mul_b = MUL_W'(diff_mag);
      end
      ST_FF: begin
        mul_a = MUL_W'(f_mag);
        mul_b = MUL_W'(f_mag);
      end
      ST_IDLE, ST_BL, ST_PUSH, ST_OUT: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = rdy_i ? ST_LX : ST_FF;
        end
      end
      ST_LX:   state_next = ST_SS;
      ST_SS:   state_next = ST_LQL;
      ST_LQL:  state_next = ST_LQH;
      ST_LQH:  state_next = ST_DD;
      ST_DD:   state_next = ST_TT;
      ST_TT:   state_next = ST_RL;
      ST_RL:   state_next = ST_RH;
      ST_RH:   state_next = ST_CMP;
      ST_CMP:  state_next = ST_DEC;
      ST_DEC:  state_next = ST_BL;
      ST_BL:   state_next = ST_FF;
      ST_FF:   state_next = ST_PUSH;
      ST_PUSH: state_next = ST_OUT;
      ST_OUT: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ring memory: read on acceptance, write back at push
  always_ff @(posedge clk) begin
    if (state == ST_PUSH) begin
      mem[wi_q] <= f_q;
    end
    if (accept) begin
      rd_q <= mem[wi_eff];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          x_q    <= x_in;
          f_q    <= x_in;
          rdy_q  <= rdy_i;
          flag_q <= 1'b0;
        end
      end
      ST_SS: begin
        d_pos_q <= !d[MUL_W-1] && (d != '0);
        d_mag_q <= d[MUL_W-1] ? SUM_W'(-d) : SUM_W'(d);
      end
      ST_LQL:  var_q <= VAR_W'(0) - prod;
      ST_LQH:  var_q <= var_q + prod;
      ST_DD:   var_q <= var_q + {prod[MUL_W-1:0], 32'b0};
      ST_TT:   lhs_q <= CMP_W'({prod, 16'b0});
      ST_RL:   thr2_q <= prod[MUL_W-1:0];
      ST_RH:   rhs_q <= CMP_W'(prod);
      ST_CMP:  rhs_q <= rhs_q + {prod, 32'b0};
      ST_DEC: begin
        flag_q <= (lhs_q > rhs_q);
        bneg_q <= diff[VAL_W];
      end
      ST_BL: begin
        if (flag_q) begin
          f_q <= blend;
        end
      end
      ST_LX, ST_FF, ST_PUSH, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      wl_q      <= LEN_RESET;
      thr_q     <= THR_RESET;
      infl_q    <= INFL_RESET;
      sum_q     <= '0;
      sq_q      <= '0;
      fill_q    <= '0;
      wi_q      <= '0;
      last_q    <= '0;
    end else begin
      state <= state_next;

      if (accept) begin
        fill_q <= fill_eff;
        wi_q   <= wi_eff;
        if (clr) begin
          sum_q <= '0;
          sq_q  <= '0;
        end
      end

      // drop the outgoing value from the sums
      if (state == ST_DEC) begin
        sum_q <= sum_q - SUM_W'(rd_q);
        sq_q  <= sq_q - prod[SQ_W-1:0];
      end

      if (state == ST_PUSH) begin
        sum_q  <= sum_q + SUM_W'(f_q);
        sq_q   <= sq_q + prod[SQ_W-1:0];
        wi_q   <= wi_next;
        last_q <= f_q;
        if (!rdy_q) begin
          fill_q <= fill_q + LEN_W'(1);
        end
      end

      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if ((state == ST_OUT) && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH: begin
            wl_q   <= cfg_data[LEN_W-1:0];
            sum_q  <= '0;
            sq_q   <= '0;
            fill_q <= '0;
            wi_q   <= '0;
          end
          CFG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
          CFG_INFLUENCE: infl_q <= cfg_data[INFL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!res_valid || res_ready)) begin
      res_data.peak_signal <= flag_q ? (d_pos_q ? SIG_POS : SIG_NEG) : SIG_NONE;
      res_data.ready_res   <= rdy_q;
    end
  end

endmodule

// ----- sv/szpd_checker.sv -----
module szpd_checker
  import szpd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 smp_valid,
  input logic                 smp_ready,
  input smp_item_t            smp_data,
  input logic                 res_valid,
  input logic                 res_ready,
  input res_item_t            res_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result item changed while stalled");

  a_fill_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.ready_res |-> res_data.peak_signal == SIG_NONE)
    else $error("peak flagged while window still filling");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    smp_valid && smp_ready |=> !smp_ready)
    else $error("second item taken while one is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    smp_valid && smp_ready && !res_valid |=> !res_valid)
    else $error("result appeared in the cycle after acceptance");

endmodule

bind smoothed_zscore_peak_detector szpd_checker u_szpd_checker (.*);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import szpd_pkg::*;

  localparam int unsigned WIN_MAX = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int N_FIXED = 9;
  localparam int N_PHASE = 15;
  localparam int PHASE_ITEMS = 72;
  localparam int PH_LEN [N_FIXED] = '{16, 2, 64, 127, 0, 5, 3, 8, 1};
  localparam int PH_THR [N_FIXED] = '{768, 768, 512, 768, 256, 0, 65535, 384, 128};
  localparam int PH_INF [N_FIXED] = '{0, 65536, 32768, 16384, 0, 65536, 0, 131071, 5000};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 smp_valid = 1'b0;
  logic                 smp_ready;
  smp_item_t            smp_data  = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  res_item_t            res_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  smp_item_t sample_q[$];
  res_item_t signal_q[$];
  int        err_count  = 0;
  int        res_count  = 0;
  bit        smp_took   = 1'b0;
  int        burst_left = 0;
  int        gap_left   = 0;
  int        hold_left  = 0;
  int        hold_mark  = 300;
  int        rx_cyc     = 0;
  int        rx_mode    = 0;

  longint            ring [WIN_MAX];
  longint            win_sum  = 0;
  longint unsigned   win_sq   = 0;
  int unsigned       fill_cnt = 0;
  int unsigned       wr_idx   = 0;
  longint            last_val = 0;
  logic [LEN_W-1:0]  len_reg  = LEN_RESET;
  logic [THR_W-1:0]  thr_reg  = THR_RESET;
  logic [INFL_W-1:0] infl_reg = INFL_RESET;

  smoothed_zscore_peak_detector #(
    .WINDOW_MAX(WIN_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .smp_valid(smp_valid),
    .smp_ready(smp_ready),
    .smp_data (smp_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_window();
    win_sum  = 0;
    win_sq   = 0;
    fill_cnt = 0;
    wr_idx   = 0;
  endfunction

  function automatic res_item_t predict_peak(smp_item_t it);
    int unsigned     n;
    longint          x, d, f, w, acc, old;
    longint unsigned ad, sum_mag;
    logic [127:0]    spread, lhs, rhs;
    bit              full;
    res_item_t       r;
    n = (len_reg < LEN_MIN) ? LEN_MIN : ((len_reg > WIN_MAX) ? WIN_MAX : len_reg);
    x = longint'(it.sample) * 256;
    if (it.restart || fill_cnt > n) clear_window();
    full = (fill_cnt == n);
    f = x;
    r.peak_signal = SIG_NONE;
    r.ready_res = full;
    if (full) begin
      d = longint'(n) * x - win_sum;
      ad = (d < 0) ? -d : d;
      sum_mag = (win_sum < 0) ? -win_sum : win_sum;
      spread = 128'(n) * 128'(win_sq) - 128'(sum_mag) * 128'(sum_mag);
      lhs = (128'(ad) * 128'(ad)) << 16;
      rhs = spread * 128'(thr_reg) * 128'(thr_reg);
      if (lhs > rhs) begin
        w = (infl_reg > INFL_ONE) ? INFL_ONE : infl_reg;
        acc = w * x + (longint'(INFL_ONE) - w) * last_val;
        f = (acc + 32768) >>> 16;
        r.peak_signal = (d > 0) ? SIG_POS : SIG_NEG;
      end
    end
    if (wr_idx >= n) wr_idx = 0;
    if (full) begin
      old = ring[wr_idx];
      win_sum -= old;
      win_sq -= old * old;
    end else begin
      fill_cnt++;
    end
    ring[wr_idx] = f;
    win_sum += f;
    win_sq += f * f;
    wr_idx = (wr_idx + 1 >= n) ? 0 : wr_idx + 1;
    last_val = f;
    return r;
  endfunction

  function automatic void push_item(int v, bit rs);
    smp_item_t it;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    it.sample = v[SMP_W-1:0];
    it.restart = rs;
    sample_q.push_back(it);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_LENGTH: begin
        len_reg = val[LEN_W-1:0];
        clear_window();
      end
      CFG_THRESHOLD: thr_reg = val[THR_W-1:0];
      CFG_INFLUENCE: infl_reg = val[INFL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int ln, int th, int inf);
    write_reg(CFG_WINDOW_LENGTH, {10'($urandom), 7'(ln)});
    write_reg(CFG_THRESHOLD, {1'($urandom), 16'(th)});
    write_reg(CFG_INFLUENCE, 17'(inf));
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (sample_q.size() != 0 || signal_q.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic add_buffer(int n, int style);
    int base, amp, v;
    base = int'($urandom_range(0, 65535)) - 32768;
    amp = $urandom_range(0, 300);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          v = base + int'($urandom_range(0, 2 * amp)) - amp;
          if ($urandom_range(0, 9) == 0)
            v = $urandom_range(0, 1) ? base + int'($urandom_range(500, 40000))
                                     : base - int'($urandom_range(500, 40000));
        end
        1: v = int'($urandom_range(0, 65535)) - 32768;
        default: v = ($urandom_range(0, 15) == 0) ? base + int'($urandom_range(0, 4)) - 2
                                                  : base;
      endcase
      push_item(v, (i == 0 && $urandom_range(0, 7) != 0) ||
                   (style == 1 && $urandom_range(0, 39) == 0));
    end
  endtask

  // sender: bursts with random gaps, hold the item until taken
  always @(negedge clk) begin
    if (!(smp_valid && !smp_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        smp_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        smp_valid <= 1'b1;
        smp_data  <= sample_q[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        smp_valid <= 1'b0;
      end
    end
    smp_took = 1'b0;
  end

  // receiver: stall pattern picked at random per period of rx_cyc, with long hold-offs
  always @(negedge clk) begin
    if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
    rx_cyc++;
    if (hold_left == 0 && res_count >= hold_mark) begin
      hold_left = 500;
      hold_mark += 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: res_ready <= 1'b1;
        1: res_ready <= 1'($urandom_range(0, 1));
        2: res_ready <= ($urandom_range(0, 3) == 0);
        default: res_ready <= (rx_cyc % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : mon
    res_item_t want;
    if (!rst && smp_valid && smp_ready) begin
      signal_q.push_back(predict_peak(smp_data));
      void'(sample_q.pop_front());
      smp_took = 1'b1;
    end
    if (!rst && res_valid && res_ready) begin
      res_count++;
      if (signal_q.size() == 0) begin
        $error("result item with none expected");
        err_count++;
      end else begin
        want = signal_q.pop_front();
        if (res_data.peak_signal !== want.peak_signal) begin
          $error("peak_signal: expected %0d, actual %0d", want.peak_signal,
                 res_data.peak_signal);
          err_count++;
        end
        if (res_data.ready_res !== want.ready_res) begin
          $error("ready_res: expected %0d, actual %0d", want.ready_res, res_data.ready_res);
          err_count++;
        end
      end
    end
  end

  initial begin
    int ln, th, inf, eff, n, left, sel;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // shortest window, full influence
    set_config(2, 768, 131071);
    push_item(100, 1);
    push_item(100, 0);
    push_item(100, 0);
    push_item(101, 0);
    push_item(-32768, 0);
    push_item(32767, 0);
    push_item(32767, 0);
    push_item(32767, 0);
    push_item(-32768, 0);
    push_item(0, 1);
    push_item(0, 0);
    push_item(-1, 0);
    push_item(32767, 1);
    push_item(-32768, 0);
    push_item(-32768, 0);
    wait_idle();

    // length below range, zero threshold, no influence
    set_config(1, 0, 0);
    push_item(5, 1);
    push_item(7, 0);
    push_item(6, 0);
    push_item(6, 0);
    push_item(6, 0);
    push_item(-5, 0);
    wait_idle();
    write_reg(CFG_SPARE, 17'($urandom));
    push_item(6, 0);
    push_item(6, 0);
    wait_idle();

    for (int p = 0; p < N_PHASE; p++) begin
      if (p < N_FIXED) begin
        ln = PH_LEN[p];
        th = PH_THR[p];
        inf = PH_INF[p];
      end else begin
        ln = $urandom_range(2, 12);
        th = $urandom_range(64, 1024);
        inf = $urandom_range(0, 131071);
      end
      set_config(ln, th, inf);
      eff = (ln < 2) ? 2 : ((ln > WIN_MAX) ? WIN_MAX : ln);
      left = PHASE_ITEMS + eff;
      while (left > 0) begin
        sel = $urandom_range(0, 7);
        if (sel == 7) n = $urandom_range(1, eff);
        else n = eff + $urandom_range(4, 2 * eff + 16);
        if (n > left) n = left;
        add_buffer(n, (sel < 4) ? 0 : ((sel == 4) ? 1 : ((sel == 5) ? 2 : $urandom_range(0, 2))));
        left -= n;
      end
      wait_idle();
    end

    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/szpd_pkg.sv
sv/szpd_mul.sv
sv/smoothed_zscore_peak_detector.sv
sv/szpd_checker.sv
tb/sv/tb_top.sv
